// File: sv/ddq_pkg.sv
package ddq_pkg;

	// sizes
	localparam int unsigned DEPTH       = 16;
	localparam int unsigned ENTRY_WIDTH = 64;
	localparam int unsigned FIELD_W     = 64;
	localparam int unsigned OP_W        = 3;
	localparam int unsigned STATUS_W    = 2;
	localparam int unsigned COUNT_W     = 5;
	localparam int unsigned FILL_W      = $clog2(DEPTH + 1);

	typedef logic [ENTRY_WIDTH-1:0] entry_t;
	typedef logic [FILL_W-1:0]      fill_t;

	// operation codes, codes 6 and 7 fall to the default arm
	typedef enum logic [OP_W-1:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_PEEK_FRONT = 3'd4,
		OP_FLUSH      = 3'd5
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// per-cell load and tap controls
	typedef struct packed {
		logic take_left;
		logic take_right;
		logic take_entry;
		logic tap;
	} cell_ctrl_t;

endpackage

// File: sv/ddq_in_if.sv
interface ddq_in_if;
	logic                               valid;
	logic                               ready;
	logic [ddq_pkg::OP_W-1:0]           op;
	logic                               queue_sel;
	logic [ddq_pkg::FIELD_W-1:0]        entry_in;

	modport source (output valid, op, queue_sel, entry_in, input ready);
	modport sink (input valid, op, queue_sel, entry_in, output ready);
endinterface

// File: sv/ddq_out_if.sv
interface ddq_out_if;
	logic                               valid;
	logic                               ready;
	logic [ddq_pkg::STATUS_W-1:0]       status;
	logic [ddq_pkg::FIELD_W-1:0]        entry_out;
	logic [ddq_pkg::COUNT_W-1:0]        count_after;

	modport source (output valid, status, entry_out, count_after, input ready);
	modport sink (input valid, status, entry_out, count_after, output ready);
endinterface

// File: sv/ddq_cell.sv
module ddq_cell (
	input  logic                clk,
	input  ddq_pkg::cell_ctrl_t ctrl,
	input  ddq_pkg::entry_t     left,
	input  ddq_pkg::entry_t     right,
	input  ddq_pkg::entry_t     entry,
	output ddq_pkg::entry_t     data_q,
	output ddq_pkg::entry_t     tap
);

	// shift from a neighbor or load the pushed word
	always_ff @(posedge clk) begin
		if (ctrl.take_left) begin
			data_q <= left;
		end else if (ctrl.take_right) begin
			data_q <= right;
		end else if (ctrl.take_entry) begin
			data_q <= entry;
		end
	end

	// gated tap for the back read
	assign tap = ctrl.tap ? data_q : '0;

endmodule

// File: sv/ddq_chain.sv
module ddq_chain (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            go,
	input  ddq_pkg::op_t    op,
	input  logic            flush,
	input  ddq_pkg::entry_t entry,
	output ddq_pkg::fill_t  fill_q,
	output ddq_pkg::entry_t front,
	output ddq_pkg::entry_t back
);

	localparam int unsigned N = ddq_pkg::DEPTH;
	localparam int unsigned W = ddq_pkg::FILL_W;

	ddq_pkg::entry_t data [N];
	ddq_pkg::entry_t taps [N];
	ddq_pkg::fill_t  tail_idx;
	logic            is_push;
	logic            is_pop;
	logic            push_ok;
	logic            pop_ok;

	// accepted operations on this queue
	assign is_push  = (op == ddq_pkg::OP_PUSH_BACK) || (op == ddq_pkg::OP_PUSH_FRONT);
	assign is_pop   = (op == ddq_pkg::OP_POP_FRONT) || (op == ddq_pkg::OP_POP_BACK);
	assign push_ok  = go && is_push && (fill_q != W'(N));
	assign pop_ok   = go && is_pop && (fill_q != '0);
	assign tail_idx = fill_q - 1'b1;

	// fill counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (flush) begin
			fill_q <= '0;
		end else if (push_ok) begin
			fill_q <= fill_q + 1'b1;
		end else if (pop_ok) begin
			fill_q <= fill_q - 1'b1;
		end
	end

	// row of cells, front at cell 0
	for (genvar i = 0; i < N; i++) begin : g_cell
		ddq_pkg::cell_ctrl_t ctrl;
		ddq_pkg::entry_t     left_w;
		ddq_pkg::entry_t     right_w;

		if (i == 0) begin : g_first
			assign left_w = entry;
		end else begin : g_inner_l
			assign left_w = data[i-1];
		end
		if (i == N - 1) begin : g_last
			assign right_w = data[i];
		end else begin : g_inner_r
			assign right_w = data[i+1];
		end

		assign ctrl.take_left  = push_ok && (op == ddq_pkg::OP_PUSH_FRONT);
		assign ctrl.take_right = pop_ok && (op == ddq_pkg::OP_POP_FRONT);
		assign ctrl.take_entry = push_ok && (op == ddq_pkg::OP_PUSH_BACK)
			&& (fill_q == W'(i));
		assign ctrl.tap        = (tail_idx == W'(i));

		ddq_cell u_cell (
			.clk    (clk),
			.ctrl   (ctrl),
			.left   (left_w),
			.right  (right_w),
			.entry  (entry),
			.data_q (data[i]),
			.tap    (taps[i])
		);
	end

	// back word is the one tapped cell
	always_comb begin
		back = '0;
		for (int k = 0; k < N; k++) begin
			back = back | taps[k];
		end
	end

	assign front = data[0];

endmodule

// File: sv/dual_double_ended_queue_top.sv
// channel | dir | beat payload
// in_ch   | in  | op, queue_sel, entry_in
// out_ch  | out | status, entry_out, count_after
//
// one beat in, one beat out; a new beat is taken every cycle while out_ch drains
// the result appears in the cycle after acceptance, from the output register
// each queue is a row of DEPTH shift cells; push front and pop front shift the row
// reset clears both fill counters; cell contents stay undefined until written
// in_ch.ready drops only while a result waits on a stalled out_ch
module dual_double_ended_queue_top (
	input  logic      clk,
	input  logic      arst_n,
	ddq_in_if.sink    in_ch,
	ddq_out_if.source out_ch
);

	ddq_pkg::op_t     op_w;
	ddq_pkg::entry_t  entry_w;
	logic             in_acc;
	logic             flush_w;
	ddq_pkg::fill_t   fill_a;
	ddq_pkg::fill_t   fill_b;
	ddq_pkg::entry_t  front_a;
	ddq_pkg::entry_t  front_b;
	ddq_pkg::entry_t  back_a;
	ddq_pkg::entry_t  back_b;
	ddq_pkg::fill_t   fill_cur;
	ddq_pkg::entry_t  front_cur;
	ddq_pkg::entry_t  back_cur;
	ddq_pkg::status_t status_d;
	ddq_pkg::entry_t  read_d;
	ddq_pkg::fill_t   count_d;
	logic             full_w;
	logic             empty_w;

	logic                         out_valid_q;
	ddq_pkg::status_t             status_q;
	logic [ddq_pkg::FIELD_W-1:0]  entry_q;
	logic [ddq_pkg::COUNT_W-1:0]  count_q;

	// input decode
	assign op_w    = ddq_pkg::op_t'(in_ch.op);
	assign entry_w = in_ch.entry_in[ddq_pkg::ENTRY_WIDTH-1:0];
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign in_acc  = in_ch.valid && in_ch.ready;
	assign flush_w = in_acc && (op_w == ddq_pkg::OP_FLUSH);

	// the two queues
	ddq_chain u_chain_a (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (in_acc && !in_ch.queue_sel),
		.op     (op_w),
		.flush  (flush_w),
		.entry  (entry_w),
		.fill_q (fill_a),
		.front  (front_a),
		.back   (back_a)
	);

	ddq_chain u_chain_b (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (in_acc && in_ch.queue_sel),
		.op     (op_w),
		.flush  (flush_w),
		.entry  (entry_w),
		.fill_q (fill_b),
		.front  (front_b),
		.back   (back_b)
	);

	// selected queue view
	assign fill_cur  = in_ch.queue_sel ? fill_b : fill_a;
	assign front_cur = in_ch.queue_sel ? front_b : front_a;
	assign back_cur  = in_ch.queue_sel ? back_b : back_a;
	assign full_w    = (fill_cur == ddq_pkg::FILL_W'(ddq_pkg::DEPTH));
	assign empty_w   = (fill_cur == '0);

	// result of the operation
	always_comb begin
		status_d = ddq_pkg::ST_OK;
		read_d   = '0;
		count_d  = fill_cur;
		case (op_w)
			ddq_pkg::OP_PUSH_BACK, ddq_pkg::OP_PUSH_FRONT: begin
				if (full_w) begin
					status_d = ddq_pkg::ST_FULL;
				end else begin
					count_d = fill_cur + 1'b1;
				end
			end
			ddq_pkg::OP_POP_FRONT: begin
				if (empty_w) begin
					status_d = ddq_pkg::ST_EMPTY;
				end else begin
					read_d  = front_cur;
					count_d = fill_cur - 1'b1;
				end
			end
			ddq_pkg::OP_POP_BACK: begin
				if (empty_w) begin
					status_d = ddq_pkg::ST_EMPTY;
				end else begin
					read_d  = back_cur;
					count_d = fill_cur - 1'b1;
				end
			end
			ddq_pkg::OP_PEEK_FRONT: begin
				if (empty_w) begin
					status_d = ddq_pkg::ST_EMPTY;
				end else begin
					read_d = front_cur;
				end
			end
			ddq_pkg::OP_FLUSH: begin
				count_d = '0;
			end
			default: begin
				count_d = fill_cur;
			end
		endcase
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			status_q <= status_d;
			entry_q  <= ddq_pkg::FIELD_W'(read_d);
			count_q  <= ddq_pkg::COUNT_W'(count_d);
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.status      = status_q;
	assign out_ch.entry_out   = entry_q;
	assign out_ch.count_after = count_q;

	// fill never exceeds the depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_a <= ddq_pkg::FILL_W'(ddq_pkg::DEPTH))
		&& (fill_b <= ddq_pkg::FILL_W'(ddq_pkg::DEPTH)))
		else $error("queue fill above depth");

	// flush empties both queues
	a_flush: assert property (@(posedge clk) disable iff (!arst_n)
		flush_w |=> (fill_a == '0) && (fill_b == '0))
		else $error("flush left entries behind");

	// an empty status carries no entry
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q == ddq_pkg::ST_EMPTY) |-> (entry_q == '0))
		else $error("empty status with nonzero entry");

	// accepted push into a non-full queue a grows it by one
	a_push_grow: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !in_ch.queue_sel && !full_w
		&& ((op_w == ddq_pkg::OP_PUSH_BACK) || (op_w == ddq_pkg::OP_PUSH_FRONT))
		|=> (fill_a == $past(fill_a) + 1'b1))
		else $error("push did not grow queue a");

	// stall only while a result is held
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> out_valid_q && !out_ch.ready)
		else $error("input stalled without a held result");

endmodule

// File: tb/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// unused op codes, the block leaves its state alone for these
	localparam logic [ddq_pkg::OP_W-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [ddq_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;

	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned HOLD_START  = 40;
	localparam int unsigned HOLD_END    = 240;
	localparam int unsigned DRAIN_WAIT  = 5;

	typedef struct {
		logic [ddq_pkg::OP_W-1:0]    op;
		logic                        sel;
		logic [ddq_pkg::FIELD_W-1:0] word;
	} queue_req_t;

	typedef struct {
		ddq_pkg::status_t             status;
		logic [ddq_pkg::FIELD_W-1:0]  entry;
		logic [ddq_pkg::COUNT_W-1:0]  count;
	} queue_resp_t;

	logic clk = 1'b0;
	logic arst_n;

	ddq_in_if  in_ch();
	ddq_out_if out_ch();

	dual_double_ended_queue_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #5 clk = ~clk;

	// requests waiting to go out and responses waiting to come back
	queue_req_t  req_q[$];
	queue_resp_t resp_q[$];

	// shadow copy of both queues
	ddq_pkg::entry_t slot[2][ddq_pkg::DEPTH];
	int unsigned     front_ix[2];
	int unsigned     held[2];

	int unsigned queued       = 0;
	int unsigned results_seen = 0;
	int unsigned send_idle    = 0;
	int unsigned take_idle    = 0;
	int unsigned rx_cycle     = 0;
	int unsigned quiet        = 0;
	logic        in_beat      = 1'b0;
	bit          failed       = 1'b0;

	// apply one operation to the shadow queues and return its response
	function automatic queue_resp_t apply_queue_op(logic [ddq_pkg::OP_W-1:0] op,
			logic sel, ddq_pkg::entry_t word);
		queue_resp_t r;
		int unsigned q;
		int unsigned ix;
		q = sel;
		r.status = ddq_pkg::ST_OK;
		r.entry  = '0;
		case (op)
			ddq_pkg::OP_PUSH_BACK: begin
				if (held[q] >= ddq_pkg::DEPTH) begin
					r.status = ddq_pkg::ST_FULL;
				end else begin
					ix = (front_ix[q] + held[q]) % ddq_pkg::DEPTH;
					slot[q][ix] = word;
					held[q]++;
				end
			end
			ddq_pkg::OP_PUSH_FRONT: begin
				if (held[q] >= ddq_pkg::DEPTH) begin
					r.status = ddq_pkg::ST_FULL;
				end else begin
					front_ix[q] = (front_ix[q] + ddq_pkg::DEPTH - 1) % ddq_pkg::DEPTH;
					slot[q][front_ix[q]] = word;
					held[q]++;
				end
			end
			ddq_pkg::OP_POP_FRONT: begin
				if (held[q] == 0) begin
					r.status = ddq_pkg::ST_EMPTY;
				end else begin
					r.entry = ddq_pkg::FIELD_W'(slot[q][front_ix[q]]);
					front_ix[q] = (front_ix[q] + 1) % ddq_pkg::DEPTH;
					held[q]--;
				end
			end
			ddq_pkg::OP_POP_BACK: begin
				if (held[q] == 0) begin
					r.status = ddq_pkg::ST_EMPTY;
				end else begin
					ix = (front_ix[q] + held[q] - 1) % ddq_pkg::DEPTH;
					r.entry = ddq_pkg::FIELD_W'(slot[q][ix]);
					held[q]--;
				end
			end
			ddq_pkg::OP_PEEK_FRONT: begin
				if (held[q] == 0) begin
					r.status = ddq_pkg::ST_EMPTY;
				end else begin
					r.entry = ddq_pkg::FIELD_W'(slot[q][front_ix[q]]);
				end
			end
			ddq_pkg::OP_FLUSH: begin
				front_ix[0] = 0;
				front_ix[1] = 0;
				held[0] = 0;
				held[1] = 0;
			end
			default: begin
			end
		endcase
		r.count = ddq_pkg::COUNT_W'(held[q]);
		return r;
	endfunction

	task automatic add_req(logic [ddq_pkg::OP_W-1:0] op, logic sel,
			logic [ddq_pkg::FIELD_W-1:0] word);
		queue_req_t r;
		r.op   = op;
		r.sel  = sel;
		r.word = word;
		req_q.insert(req_q.size(), r);
		queued++;
	endtask

	function automatic logic [ddq_pkg::FIELD_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// one run of related requests: fill a queue, drain it, mix, or noise
	task automatic add_burst();
		int unsigned kind;
		int unsigned len;
		logic        sel;
		logic        s;
		logic [ddq_pkg::OP_W-1:0] op;
		kind = $urandom_range(9);
		len  = $urandom_range(24, 4);
		sel  = 1'($urandom_range(1));
		for (int unsigned i = 0; i < len; i++) begin
			s = ($urandom_range(7) == 0) ? ~sel : sel;
			if (kind <= 3) begin
				if ($urandom_range(5) == 0)
					op = ddq_pkg::op_t'($urandom_range(ddq_pkg::OP_PEEK_FRONT,
						ddq_pkg::OP_POP_FRONT));
				else
					op = $urandom_range(1) ? ddq_pkg::OP_PUSH_BACK : ddq_pkg::OP_PUSH_FRONT;
			end else if (kind <= 6) begin
				if ($urandom_range(5) == 0)
					op = $urandom_range(1) ? ddq_pkg::OP_PUSH_BACK : ddq_pkg::OP_PUSH_FRONT;
				else
					op = ddq_pkg::op_t'($urandom_range(ddq_pkg::OP_PEEK_FRONT,
						ddq_pkg::OP_POP_FRONT));
			end else if (kind <= 8) begin
				op = ddq_pkg::op_t'($urandom_range(ddq_pkg::OP_PEEK_FRONT));
				s  = 1'($urandom_range(1));
			end else begin
				op = ddq_pkg::OP_W'($urandom_range(OP_SPARE_HI));
				s  = 1'($urandom_range(1));
			end
			add_req(op, s, rand_word());
		end
	endtask

	// sender: offer the next request once the current beat is taken
	always @(negedge clk) begin : drive_req
		queue_req_t r;
		if (arst_n && (!in_ch.valid || in_beat)) begin
			if (req_q.size() != 0 && $urandom_range(99) >= send_idle) begin
				r = req_q[0];
				req_q.delete(0);
				in_ch.valid     <= 1'b1;
				in_ch.op        <= r.op;
				in_ch.queue_sel <= r.sel;
				in_ch.entry_in  <= r.word;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls plus one long hold-off early on
	always @(negedge clk) begin
		if (arst_n) begin
			rx_cycle <= rx_cycle + 1;
			if (rx_cycle >= HOLD_START && rx_cycle < HOLD_END)
				out_ch.ready <= 1'b0;
			else
				out_ch.ready <= ($urandom_range(99) >= take_idle);
		end
	end

	// check response beats, then predict from request beats
	always @(posedge clk) begin : watch_beats
		queue_resp_t want;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				results_seen <= results_seen + 1;
				if (resp_q.size() == 0) begin
					$error("response beat with none outstanding");
					failed = 1'b1;
				end else begin
					want = resp_q[0];
					resp_q.delete(0);
					if (out_ch.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, out_ch.status);
						failed = 1'b1;
					end
					if (out_ch.entry_out !== want.entry) begin
						$error("entry_out: expected %0h, got %0h", want.entry,
							out_ch.entry_out);
						failed = 1'b1;
					end
					if (out_ch.count_after !== want.count) begin
						$error("count_after: expected %0d, got %0d", want.count,
							out_ch.count_after);
						failed = 1'b1;
					end
				end
			end
			in_beat <= in_ch.valid && in_ch.ready;
			if (in_ch.valid && in_ch.ready)
				resp_q.insert(resp_q.size(), apply_queue_op(in_ch.op, in_ch.queue_sel,
					in_ch.entry_in[ddq_pkg::ENTRY_WIDTH-1:0]));
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("dual_double_ended_queue_top test failed");
				$finish;
			end
		end
	end

	initial begin
		int unsigned target;
		in_ch.valid     = 1'b0;
		in_ch.op        = ddq_pkg::OP_PUSH_BACK;
		in_ch.queue_sel = 1'b0;
		in_ch.entry_in  = '0;
		out_ch.ready    = 1'b0;
		front_ix[0] = 0;
		front_ix[1] = 0;
		held[0] = 0;
		held[1] = 0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty reads, word extremes, both ends, unused codes, flush
		send_idle = 31;
		take_idle = 57;
		add_req(ddq_pkg::OP_POP_FRONT, 1'b0, rand_word());
		add_req(ddq_pkg::OP_PEEK_FRONT, 1'b1, rand_word());
		add_req(ddq_pkg::OP_POP_BACK, 1'b1, rand_word());
		add_req(ddq_pkg::OP_PUSH_BACK, 1'b0, '1);
		add_req(ddq_pkg::OP_PUSH_FRONT, 1'b0, '0);
		add_req(ddq_pkg::OP_PUSH_BACK, 1'b1, {(ddq_pkg::FIELD_W/4){4'h5}});
		add_req(ddq_pkg::OP_PUSH_FRONT, 1'b1, {(ddq_pkg::FIELD_W/4){4'hA}});
		add_req(ddq_pkg::OP_PEEK_FRONT, 1'b0, rand_word());
		add_req(ddq_pkg::OP_POP_BACK, 1'b0, rand_word());
		add_req(ddq_pkg::OP_POP_FRONT, 1'b1, rand_word());
		add_req(OP_SPARE_LO, 1'b0, rand_word());
		add_req(OP_SPARE_HI, 1'b1, rand_word());
		add_req(ddq_pkg::OP_PUSH_BACK, 1'b0, {1'b1, {(ddq_pkg::FIELD_W-2){1'b0}}, 1'b1});
		add_req(ddq_pkg::OP_FLUSH, 1'b1, rand_word());
		add_req(ddq_pkg::OP_PEEK_FRONT, 1'b0, rand_word());
		add_req(ddq_pkg::OP_POP_BACK, 1'b1, rand_word());
		add_req(ddq_pkg::OP_PUSH_FRONT, 1'b1, rand_word());
		add_req(ddq_pkg::OP_POP_BACK, 1'b1, rand_word());
		add_req(ddq_pkg::OP_POP_FRONT, 1'b0, rand_word());

		// three phases of random bursts, the last with no idling
		for (int ph = 0; ph < 3; ph++) begin
			@(posedge clk);
			send_idle = (ph == 0) ? 31 : (ph == 1) ? 57 : 0;
			take_idle = (ph == 0) ? 57 : (ph == 1) ? 31 : 0;
			target = 20 + (ph + 1) * 445;
			while (queued < target)
				add_burst();
			while (results_seen != queued)
				@(negedge clk);
		end
		repeat (DRAIN_WAIT) @(negedge clk);

		if (!failed && resp_q.size() == 0) begin
			$display("dual_double_ended_queue_top test passed");
		end else begin
			$display("dual_double_ended_queue_top test failed");
		end
		$finish;
	end

endmodule
